/* src/solenoid_peak_hold_driver_core_macros.svh */
// Assertion macros for the peak-and-hold driver core.
// Expects clk and rst (synchronous, active high) in the including module.
`ifndef SOLENOID_PEAK_HOLD_DRIVER_CORE_MACROS_SVH
`define SOLENOID_PEAK_HOLD_DRIVER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SPHD_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SPHD_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/sphd_pkg.sv */
// Types, constants and helpers of the peak-and-hold solenoid driver core.
// No dependencies; imported by solenoid_peak_hold_driver_core.
`timescale 1ns / 1ps

package sphd_pkg;

  localparam int CHANNELS_DEF = 4;
  localparam int CFG_IDX_W    = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PWM_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OPEN_DUTY  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_DUTY  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OPEN_TICKS = 2'd3;

  localparam logic [15:0] PWM_PERIOD_RST = 16'd7500;
  localparam logic [6:0]  OPEN_DUTY_RST  = 7'd100;
  localparam logic [6:0]  HOLD_DUTY_RST  = 7'd20;
  localparam logic [7:0]  OPEN_TICKS_RST = 8'd2;
  localparam logic [6:0]  PCT_MAX        = 7'd100;

  // ceil(2^30 / 100): exact quotient by 100 for any product below 2^23
  localparam logic [23:0] RECIP_100   = 24'd10737419;
  localparam int          RECIP_SHIFT = 30;

  typedef enum logic [1:0] {
    CMD_SWITCH   = 2'd0,
    CMD_SET_DUTY = 2'd1,
    CMD_TOGGLE   = 2'd2,
    CMD_TICK     = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    PH_OFF  = 2'd0,
    PH_OPEN = 2'd1,
    PH_HOLD = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    TAG_CMD = 2'd0,
    TAG_UPD = 2'd1,
    TAG_REP = 2'd2
  } tag_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE     = 2'd0,
    ST_TICK_UPD = 2'd1,
    ST_TICK_REP = 2'd2,
    ST_DRAIN    = 2'd3
  } state_t;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] channel;
    logic [7:0] value;
  } item_t;

  typedef struct packed {
    logic [4:0]  chan_out;
    logic        accepted;
    logic [6:0]  duty_pct;
    logic [1:0]  phase;
    logic [15:0] pwm_compare;
    logic        is_on;
    logic        return_enable;
    logic        last;
  } result_t;

  typedef struct packed {
    phase_t     phase;
    logic [7:0] countdown;
    logic [6:0] duty;
  } entry_t;

  localparam entry_t ENTRY_RST = '{phase: PH_OFF, countdown: 8'd0, duty: 7'd0};

  // Marks what the data coming back from the channel memory is for
  typedef struct packed {
    logic      valid;
    tag_kind_t kind;
    logic      last;
    logic      bad;
  } tag_t;

  function automatic logic [6:0] clamp_pct(input logic [7:0] v);
    logic [6:0] r;
    r = (v > {1'b0, PCT_MAX}) ? PCT_MAX : v[6:0];
    return r;
  endfunction

endpackage

/* src/solenoid_peak_hold_driver_core.sv */
// Peak-and-hold solenoid valve sequencer: channel state memory, command
// sequencer and PWM compare pipeline. Depends on sphd_pkg and the macro header.
`timescale 1ns / 1ps
`include "solenoid_peak_hold_driver_core_macros.svh"

// Start an item with start while busy is low. Switch, set duty and toggle give
// one result each; busy holds off the next item until that result has left
// the first report register. A tick walks the channel memory twice, once to count
// every open channel down and once to report channels 1..CHANNELS, so it
// gives CHANNELS results on consecutive cycles. The channel memory has a single
// read and a single write port. Each result shows on result for exactly one
// cycle with strobe high and cannot be held off. Configuration writes are
// always taken (cfg_ready high) and must come only while the block is idle.
module solenoid_peak_hold_driver_core
  import sphd_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  item_t                item,
  output logic                 strobe,
  output result_t              result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CHANNELS - 1);

  // Configuration registers
  logic [15:0] pwm_period;
  logic [6:0]  open_duty;
  logic [6:0]  hold_duty;
  logic [7:0]  open_ticks;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_period <= PWM_PERIOD_RST;
      open_duty  <= OPEN_DUTY_RST;
      hold_duty  <= HOLD_DUTY_RST;
      open_ticks <= OPEN_TICKS_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PWM_PERIOD: pwm_period <= cfg_data;
        REG_OPEN_DUTY:  open_duty  <= cfg_data[6:0];
        REG_HOLD_DUTY:  hold_duty  <= cfg_data[6:0];
        REG_OPEN_TICKS: open_ticks <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Sequencer
  state_t          state, state_next;
  logic [IDX_W-1:0] cnt, cnt_next;
  item_t           cur;
  tag_t            tag, tag_next;
  logic [IDX_W-1:0] tag_idx, tag_idx_next;
  logic            rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic            accept;
  logic            chan_ok;
  logic [IDX_W-1:0] item_idx;
  logic            rep1_valid;

  assign busy     = (state != ST_IDLE);
  assign accept   = start && !busy;
  assign chan_ok  = (item.channel != 8'd0) && (item.channel <= 8'(CHANNELS));
  assign item_idx = IDX_W'(item.channel - 8'd1);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          if (cmd_t'(item.command) == CMD_TICK) begin
            state_next = (LAST_IDX == '0) ? ST_TICK_REP : ST_TICK_UPD;
          end else begin
            state_next = ST_DRAIN;
          end
        end
      end
      ST_TICK_UPD: begin
        if (cnt == LAST_IDX) state_next = ST_TICK_REP;
      end
      ST_TICK_REP: begin
        if (cnt == LAST_IDX) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!tag.valid && !rep1_valid) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cnt_next     = cnt;
    rd_en        = 1'b0;
    rd_addr      = cnt;
    tag_next     = '{valid: 1'b0, kind: TAG_CMD, last: 1'b0, bad: 1'b0};
    tag_idx_next = cnt;
    case (state)
      ST_IDLE: begin
        if (start) begin
          if (cmd_t'(item.command) == CMD_TICK) begin
            rd_en          = 1'b1;
            rd_addr        = '0;
            tag_idx_next   = '0;
            tag_next.valid = 1'b1;
            tag_next.kind  = TAG_UPD;
            cnt_next       = (LAST_IDX == '0) ? '0 : IDX_W'(1);
          end else begin
            rd_en          = chan_ok;
            rd_addr        = item_idx;
            tag_idx_next   = item_idx;
            tag_next.valid = 1'b1;
            tag_next.kind  = TAG_CMD;
            tag_next.last  = 1'b1;
            tag_next.bad   = !chan_ok;
          end
        end
      end
      ST_TICK_UPD: begin
        rd_en          = 1'b1;
        tag_next.valid = 1'b1;
        tag_next.kind  = TAG_UPD;
        cnt_next       = (cnt == LAST_IDX) ? '0 : cnt + IDX_W'(1);
      end
      ST_TICK_REP: begin
        rd_en          = 1'b1;
        tag_next.valid = 1'b1;
        tag_next.kind  = TAG_REP;
        tag_next.last  = (cnt == LAST_IDX);
        cnt_next       = cnt + IDX_W'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      tag.valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      tag       <= tag_next;
    end
  end

  always_ff @(posedge clk) begin
    tag_idx  <= tag_idx_next;
    if (accept) cur <= item;
  end

  // Channel memory: one read, one write per cycle, registered read data
  entry_t           mem [CHANNELS];
  logic [CHANNELS-1:0] written;
  logic [CHANNELS-1:0] on_mask;
  entry_t           mem_q;
  logic             vld_q;
  logic             hit_q;
  entry_t           fwd_q;
  logic             wr_en;
  entry_t           wr_data;
  entry_t           ent;

  always_ff @(posedge clk) begin
    if (wr_en) mem[tag_idx] <= wr_data;
    if (rd_en) mem_q <= mem[rd_addr];
    vld_q <= written[rd_addr];
    hit_q <= wr_en && (tag_idx == rd_addr);
    fwd_q <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      on_mask <= '0;
    end else if (wr_en) begin
      written[tag_idx] <= 1'b1;
      on_mask[tag_idx] <= (wr_data.duty != 7'd0);
    end
  end

  // Forward a write that lands on the entry being read; unwritten reads as reset
  assign ent = hit_q ? fwd_q : (vld_q ? mem_q : ENTRY_RST);

  // Read-modify-write of the entry that just came back
  logic   sw_on;
  logic   do_switch;
  entry_t rep_ent;
  logic   rep_push;

  always_comb begin
    wr_data   = ent;
    wr_en     = 1'b0;
    sw_on     = 1'b0;
    do_switch = 1'b0;
    case (tag.kind)
      TAG_UPD: begin
        wr_en = tag.valid;
        if (ent.phase == PH_OPEN) begin
          wr_data.countdown = (ent.countdown != 8'd0) ? ent.countdown - 8'd1 : 8'd0;
          if (wr_data.countdown == 8'd0) begin
            wr_data.phase = PH_HOLD;
            wr_data.duty  = clamp_pct({1'b0, hold_duty});
          end
        end
      end
      TAG_CMD: begin
        wr_en = tag.valid && !tag.bad;
        case (cmd_t'(cur.command))
          CMD_SWITCH: begin
            do_switch = 1'b1;
            sw_on     = (cur.value != 8'd0);
          end
          CMD_TOGGLE: begin
            do_switch = 1'b1;
            sw_on     = (ent.duty == 7'd0);
          end
          CMD_SET_DUTY: begin
            wr_data.duty      = clamp_pct(cur.value);
            wr_data.phase     = (wr_data.duty == 7'd0) ? PH_OFF : PH_HOLD;
            wr_data.countdown = 8'd0;
          end
          default: ;
        endcase
        if (do_switch) begin
          if (!sw_on) begin
            wr_data = ENTRY_RST;
          end else if (ent.phase == PH_OFF) begin
            wr_data.phase     = PH_OPEN;
            wr_data.countdown = open_ticks;
            wr_data.duty      = clamp_pct({1'b0, open_duty});
          end
        end
      end
      default: ;
    endcase
    rep_push = tag.valid && (tag.kind != TAG_UPD);
    rep_ent  = (tag.kind == TAG_REP) ? ent : wr_data;
  end

  // Report pipeline: fields, then product, then quotient by 100
  logic [4:0]  rep1_chan;
  logic        rep1_acc;
  logic [6:0]  rep1_duty;
  logic [1:0]  rep1_phase;
  logic        rep1_last;
  logic        rep2_valid;
  logic [4:0]  rep2_chan;
  logic        rep2_acc;
  logic [6:0]  rep2_duty;
  logic [1:0]  rep2_phase;
  logic        rep2_last;
  logic [22:0] rep2_prod;
  logic [22:0] prod_next;
  logic [46:0] quot_full;

  assign prod_next = (rep1_chan == 5'd1 && rep1_duty != 7'd0)
                   ? 23'(pwm_period) * 23'(PCT_MAX - rep1_duty) : 23'd0;
  assign quot_full = 47'(rep2_prod) * 47'(RECIP_100);

  always_ff @(posedge clk) begin
    if (rst) begin
      rep1_valid <= 1'b0;
      rep2_valid <= 1'b0;
      strobe     <= 1'b0;
    end else begin
      rep1_valid <= rep_push;
      rep2_valid <= rep1_valid;
      strobe     <= rep2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tag.bad) begin
      rep1_chan  <= 5'd0;
      rep1_acc   <= 1'b0;
      rep1_duty  <= 7'd0;
      rep1_phase <= PH_OFF;
    end else begin
      rep1_chan  <= 5'(tag_idx) + 5'd1;
      rep1_acc   <= 1'b1;
      rep1_duty  <= rep_ent.duty;
      rep1_phase <= rep_ent.phase;
    end
    rep1_last  <= tag.last;

    rep2_chan  <= rep1_chan;
    rep2_acc   <= rep1_acc;
    rep2_duty  <= rep1_duty;
    rep2_phase <= rep1_phase;
    rep2_last  <= rep1_last;
    rep2_prod  <= prod_next;

    result.chan_out      <= rep2_chan;
    result.accepted      <= rep2_acc;
    result.duty_pct      <= rep2_duty;
    result.phase         <= rep2_phase;
    result.pwm_compare   <= quot_full[RECIP_SHIFT+15:RECIP_SHIFT];
    result.is_on         <= (rep2_duty != 7'd0);
    result.return_enable <= |on_mask;
    result.last          <= rep2_last;
  end

  `SPHD_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy did not rise after accept")
  `SPHD_ASSERT_NEXT(a_tick_burst, strobe && !result.last,
    strobe && result.chan_out == $past(result.chan_out) + 5'd1, "tick results broken")
  `SPHD_ASSERT_NOW(a_cmp_chan1, strobe && result.pwm_compare != 16'd0,
    result.chan_out == 5'd1, "compare value on channel other than one")
  `SPHD_ASSERT_NOW(a_on_return, strobe && result.is_on, result.return_enable,
    "channel on but return enable low")

endmodule

/* test/solenoid_peak_hold_driver_core_tb.sv */
// Self-checking testbench of solenoid_peak_hold_driver_core: directed and random
// commands under changing register settings, checked against a scoreboard model.
// Depends on sphd_pkg and the core RTL only.
`timescale 1ns / 1ps

module solenoid_peak_hold_driver_core_tb;
  import sphd_pkg::*;

  localparam int CH        = CHANNELS_DEF;
  localparam int SETTLE    = 2 * CH + 8;
  localparam int LIMIT     = 200000;
  localparam int PHASES    = 6;
  localparam int PER_PHASE = 58;

  // Channel state model plus the queue of results still owed by the core
  class valve_scoreboard;
    phase_t      ph_st[CH];
    logic [7:0]  countdown[CH];
    logic [6:0]  duty[CH];
    logic [15:0] period;
    logic [6:0]  open_duty;
    logic [6:0]  hold_duty;
    logic [7:0]  open_ticks;
    result_t     owed[$];
    int          errors;
    int          n_items;
    int          n_ticks;
    int          n_invalid;
    int          n_results;
    int          n_writes;

    function new();
      for (int i = 0; i < CH; i++) begin
        ph_st[i] = PH_OFF;
        countdown[i] = '0;
        duty[i] = '0;
      end
      period = PWM_PERIOD_RST;
      open_duty = OPEN_DUTY_RST;
      hold_duty = HOLD_DUTY_RST;
      open_ticks = OPEN_TICKS_RST;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
      n_writes++;
      case (idx)
        REG_PWM_PERIOD: period = data;
        REG_OPEN_DUTY:  open_duty = data[6:0];
        REG_HOLD_DUTY:  hold_duty = data[6:0];
        REG_OPEN_TICKS: open_ticks = data[7:0];
        default: ;
      endcase
    endfunction

    function logic [6:0] cap_pct(logic [7:0] v);
      return (v > 8'd100) ? 7'd100 : v[6:0];
    endfunction

    function logic any_on();
      for (int i = 0; i < CH; i++)
        if (duty[i] != 0) return 1'b1;
      return 1'b0;
    endfunction

    function void set_channel(int i, bit on);
      if (on) begin
        if (ph_st[i] != PH_OFF) return;
        ph_st[i] = PH_OPEN;
        countdown[i] = open_ticks;
        duty[i] = cap_pct({1'b0, open_duty});
      end else begin
        ph_st[i] = PH_OFF;
        countdown[i] = '0;
        duty[i] = '0;
      end
    endfunction

    function result_t channel_status(int i, bit is_last);
      result_t r;
      int unsigned prod;
      prod = int'(period) * (100 - int'(duty[i]));
      r.chan_out = 5'(i + 1);
      r.accepted = 1'b1;
      r.duty_pct = duty[i];
      r.phase = ph_st[i];
      r.pwm_compare = (i == 0 && duty[i] != 0) ? 16'(prod / 100) : 16'd0;
      r.is_on = (duty[i] != 0);
      r.return_enable = any_on();
      r.last = is_last;
      return r;
    endfunction

    function void note_item(item_t it);
      result_t r;
      int i;
      n_items++;
      if (it.command == CMD_TICK) begin
        n_ticks++;
        for (i = 0; i < CH; i++) begin
          if (ph_st[i] == PH_OPEN) begin
            if (countdown[i] != 0) countdown[i]--;
            if (countdown[i] == 0) begin
              ph_st[i] = PH_HOLD;
              duty[i] = cap_pct({1'b0, hold_duty});
            end
          end
        end
        for (i = 0; i < CH; i++) owed.push_back(channel_status(i, i == CH - 1));
        return;
      end
      if (it.channel < 1 || it.channel > CH) begin
        n_invalid++;
        r = '0;
        r.return_enable = any_on();
        r.last = 1'b1;
        owed.push_back(r);
        return;
      end
      i = int'(it.channel) - 1;
      case (it.command)
        CMD_SWITCH: set_channel(i, it.value != 0);
        CMD_SET_DUTY: begin
          duty[i] = cap_pct(it.value);
          ph_st[i] = (duty[i] == 0) ? PH_OFF : PH_HOLD;
          countdown[i] = '0;
        end
        default: set_channel(i, duty[i] == 0);
      endcase
      owed.push_back(channel_status(i, 1'b1));
    endfunction

    function int field_bad(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v == act_v) return 0;
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      return 1;
    endfunction

    function void check_result(result_t r);
      result_t e;
      n_results++;
      if (owed.size() == 0) begin
        $error("result with no item pending: %p", r);
        errors++;
        return;
      end
      e = owed.pop_front();
      errors += field_bad("chan_out", e.chan_out, r.chan_out);
      errors += field_bad("accepted", e.accepted, r.accepted);
      errors += field_bad("duty_pct", e.duty_pct, r.duty_pct);
      errors += field_bad("phase", e.phase, r.phase);
      errors += field_bad("pwm_compare", e.pwm_compare, r.pwm_compare);
      errors += field_bad("is_on", e.is_on, r.is_on);
      errors += field_bad("return_enable", e.return_enable, r.return_enable);
      errors += field_bad("last", e.last, r.last);
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  item_t                item = '0;
  logic                 cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0]          cfg_data = '0;
  logic                 busy;
  logic                 strobe;
  result_t              result;
  logic                 cfg_ready;

  valve_scoreboard sb = new();
  int              cycle_count = 0;
  int              idle_pct = 0;

  solenoid_peak_hold_driver_core #(.CHANNELS(CH)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .item     (item),
    .strobe   (strobe),
    .result   (result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst && strobe === 1'b1) sb.check_result(result);
  end

  initial begin
    wait (cycle_count >= LIMIT);
    $display("timeout after %0d cycles, %0d results still owed", LIMIT, sb.owed.size());
    $display("** solenoid_peak_hold_driver_core: FAILED **");
    $finish;
  end

  function automatic item_t make_item(cmd_t cmd, int ch, int val);
    item_t it;
    it.command = cmd;
    it.channel = 8'(ch);
    it.value = 8'(val);
    return it;
  endfunction

  // Leaves start high so a following item can go out back to back
  task automatic send(item_t it);
    start <= 1'b1;
    item <= it;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_item(it);
  endtask

  task automatic pace();
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.write_reg(idx, data);
  endtask

  task automatic load_regs(int period, int od, int hd, int ot);
    put_reg(REG_PWM_PERIOD, 16'(period));
    put_reg(REG_OPEN_DUTY, 16'(od));
    put_reg(REG_HOLD_DUTY, 16'(hd));
    put_reg(REG_OPEN_TICKS, 16'(ot));
    cfg_valid <= 1'b0;
  endtask

  function automatic item_t random_item();
    item_t it;
    int unsigned roll;
    roll = $urandom_range(99);
    it.channel = ($urandom_range(99) < 85) ? 8'($urandom_range(1, CH))
                                           : 8'($urandom_range(0, 255));
    it.value = 8'($urandom_range(0, 255));
    if (roll < 30) begin
      it.command = CMD_TICK;
    end else if (roll < 60) begin
      it.command = CMD_SWITCH;
      if ($urandom_range(1)) it.value = '0;
    end else if (roll < 80) begin
      it.command = CMD_SET_DUTY;
      case ($urandom_range(5))
        0: it.value = 8'd0;
        1: it.value = 8'd100;
        2: it.value = 8'd101;
        3: it.value = 8'($urandom_range(0, 100));
        default: ;
      endcase
    end else begin
      it.command = CMD_TOGGLE;
    end
    return it;
  endfunction

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset settings, idle ticks, peak to hold, repeated on, bad channels
    idle_pct = 31;
    send(make_item(CMD_TICK, 0, 0));                pace();
    send(make_item(CMD_SWITCH, 1, 1));              pace();
    send(make_item(CMD_SWITCH, 1, 255));            pace();
    send(make_item(CMD_TICK, 255, 255));            pace();
    send(make_item(CMD_TICK, 0, 0));                pace();
    send(make_item(CMD_TICK, 0, 0));                pace();
    send(make_item(CMD_SWITCH, 0, 1));              pace();
    send(make_item(CMD_SWITCH, CH + 1, 1));         pace();
    send(make_item(CMD_SET_DUTY, 255, 50));         pace();
    send(make_item(CMD_TOGGLE, 128, 0));            pace();
    send(make_item(CMD_SET_DUTY, 2, 255));          pace();
    send(make_item(CMD_SET_DUTY, 2, 0));            pace();
    send(make_item(CMD_SET_DUTY, 3, 100));          pace();
    send(make_item(CMD_TOGGLE, 3, 0));              pace();
    send(make_item(CMD_TOGGLE, 3, 0));              pace();
    send(make_item(CMD_TOGGLE, CH, 0));             pace();
    send(make_item(CMD_SWITCH, CH, 0));             pace();
    send(make_item(CMD_SET_DUTY, 1, 1));            pace();
    send(make_item(CMD_SET_DUTY, 1, 99));           pace();
    send(make_item(CMD_SET_DUTY, 1, 101));          pace();
    send(make_item(CMD_SWITCH, 1, 0));              pace();
    send(make_item(CMD_TICK, 0, 0));

    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0: load_regs(7500, 100, 20, 2);
        1: load_regs(65535, 16'hFF7F, 16'h0065, 0);
        2: load_regs(1, 0, 0, 1);
        3: load_regs($urandom_range(1, 65535), $urandom_range(0, 65535),
                     $urandom_range(0, 65535), $urandom_range(0, 4));
        4: load_regs(65535, 100, 1, 255);
        default: load_regs($urandom_range(1, 65535), $urandom_range(0, 65535),
                           $urandom_range(0, 65535), $urandom_range(0, 7));
      endcase
      idle_pct = (p < 2) ? 31 : (p < 4) ? 82 : 0;
      for (int n = 0; n < PER_PHASE; n++) begin
        send(random_item());
        // hold off mid-phase until every owed result is back
        if (n == PER_PHASE / 2 && p % 2 == 1) drain();
        else pace();
      end
    end

    drain();
    $display("ran %0d items (%0d ticks, %0d bad channel) over %0d register writes",
             sb.n_items, sb.n_ticks, sb.n_invalid, sb.n_writes);
    $display("checked %0d results, %0d field mismatches", sb.n_results, sb.errors);
    if (sb.errors == 0) begin
      $display("** solenoid_peak_hold_driver_core: PASSED **");
    end else begin
      $display("** solenoid_peak_hold_driver_core: FAILED **");
    end
    $finish;
  end

endmodule
